FILE: hdl/fqkr_pkg.sv
// fqkr_pkg: shared types and constants of the keyed-removal identifier queue
// no dependencies; used by the interfaces, the cell, the top level and the checker
package fqkr_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int ID_WIDTH_DEF = 16;

   localparam int CMD_W     = 2;
   localparam int ITEM_ID_W = 16;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 4;
   localparam int COUNT_W   = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // per-request controls broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
      logic remove;
   } cell_ctl_type;

endpackage

FILE: hdl/fqkr_if.sv
// fqkr_req_if and fqkr_rsp_if: valid/ready channels of the identifier queue
// depends on fqkr_pkg for field widths
interface fqkr_req_if;
   logic                           valid;
   logic                           ready;
   logic [fqkr_pkg::CMD_W-1:0]     cmd;
   logic [fqkr_pkg::ITEM_ID_W-1:0] item_id;

   modport source (output valid, output cmd, output item_id, input ready);
   modport sink   (input valid, input cmd, input item_id, output ready);
endinterface

interface fqkr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fqkr_pkg::STATUS_W-1:0]  status;
   logic [fqkr_pkg::ITEM_ID_W-1:0] result_id;
   logic [fqkr_pkg::POS_W-1:0]     position;
   logic [fqkr_pkg::COUNT_W-1:0]   count;

   modport source (output valid, output status, output result_id, output position,
                   output count, input ready);
   modport sink   (input valid, input status, input result_id, input position,
                   input count, output ready);
endinterface

FILE: hdl/fqkr_cell.sv
// fqkr_cell: one slot of the queue, holding an entry and its occupied flag
// compares against the key, passes the first-match flag on, shifts from its neighbor
// depends on fqkr_pkg
module fqkr_cell #(
   parameter int ID_WIDTH = fqkr_pkg::ID_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fqkr_pkg::cell_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]    key,
   input  logic                   prev_occ,
   input  logic                   next_occ,
   input  logic [ID_WIDTH-1:0]    next_entry,
   input  logic                   seen_in,
   output logic                   occ,
   output logic [ID_WIDTH-1:0]    entry,
   output logic                   seen_out,
   output logic                   first_hit
);
   import fqkr_pkg::*;

   logic                occ_ff;
   logic                occ_in;
   logic [ID_WIDTH-1:0] entry_ff;
   logic [ID_WIDTH-1:0] entry_in;
   logic                hit;

   assign hit       = occ_ff && (entry_ff == key);
   assign seen_out  = seen_in | hit;
   assign first_hit = hit & ~seen_in;
   assign occ       = occ_ff;
   assign entry     = entry_ff;

   always_comb begin
      occ_in   = occ_ff;
      entry_in = entry_ff;
      priority if (ctl.push && !occ_ff && prev_occ) begin
         occ_in   = 1'b1;
         entry_in = key;
      end else if (ctl.pop || (ctl.remove && seen_out)) begin
         occ_in   = next_occ;
         entry_in = next_entry;
      end else begin
         occ_in   = occ_ff;
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hdl/fifo_queue_with_keyed_removal.sv
// fifo_queue_with_keyed_removal: ordered queue of identifiers with keyed removal
// depends on fqkr_pkg, fqkr_req_if, fqkr_rsp_if and fqkr_cell
//
// usage
//   req_bus carries one request: cmd (push, pop, remove by id, position query)
//   and item_id; rsp_bus returns exactly one response per request with status,
//   result_id, position and the entry count after the request
//   entries live in a row of DEPTH cells, position 0 at the head; every cell
//   compares its entry with the key in parallel and a first-match flag ripples
//   down the row, so a request is done in the cycle it is accepted
//   the response is registered and valid in the cycle after the request is accepted
//   throughput: one request per cycle while responses are taken; the match
//   ripple through the cell row sets the clock period, not the cycle count
//   reset empties the queue and drops any pending response; no request is taken
//   while reset is high; entry contents are left as they are and never read
//   before they are written
//   a stalled response holds its payload; a new request is taken only when the
//   response register is empty or being drained in the same cycle
module fifo_queue_with_keyed_removal #(
   parameter int DEPTH    = fqkr_pkg::DEPTH_DEF,
   parameter int ID_WIDTH = fqkr_pkg::ID_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   fqkr_req_if.sink req_bus,
   fqkr_rsp_if.source rsp_bus
);
   import fqkr_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic                accept;
   logic [ID_WIDTH-1:0] key;
   cell_ctl_type        ctl;

   logic [DEPTH-1:0]    occ_w;
   logic [ID_WIDTH-1:0] entry_w [DEPTH];
   logic [DEPTH:0]      seen_w;
   logic [DEPTH-1:0]    first_w;
   logic [IDX_W-1:0]    pos_w;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                full;
   logic                empty;
   logic                found;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [ITEM_ID_W-1:0]  result_id_ff;
   logic [ITEM_ID_W-1:0]  result_id_in;
   logic [POS_W-1:0]      position_ff;
   logic [POS_W-1:0]      position_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign key           = ID_WIDTH'(req_bus.item_id);

   assign ctl.push   = accept && (cmd_type'(req_bus.cmd) == CMD_PUSH);
   assign ctl.pop    = accept && (cmd_type'(req_bus.cmd) == CMD_POP);
   assign ctl.remove = accept && (cmd_type'(req_bus.cmd) == CMD_REMOVE);

   assign seen_w[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                prev_occ;
      logic                next_occ;
      logic [ID_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_head
         assign prev_occ = 1'b1;
      end else begin : g_body
         assign prev_occ = occ_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_occ   = 1'b0;
         assign next_entry = '0;
      end else begin : g_mid
         assign next_occ   = occ_w[i+1];
         assign next_entry = entry_w[i+1];
      end

      fqkr_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key),
         .prev_occ   (prev_occ),
         .next_occ   (next_occ),
         .next_entry (next_entry),
         .seen_in    (seen_w[i]),
         .occ        (occ_w[i]),
         .entry      (entry_w[i]),
         .seen_out   (seen_w[i+1]),
         .first_hit  (first_w[i])
      );
   end

   always_comb begin
      pos_w = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pos_w = pos_w | (first_w[i] ? IDX_W'(i) : '0);
      end
   end

   assign found = seen_w[DEPTH];
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      status_in    = ST_MISS;
      result_id_in = '0;
      position_in  = '0;
      count_in     = count_ff;
      unique case (cmd_type'(req_bus.cmd))
         CMD_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in    = ST_OK;
               result_id_in = ITEM_ID_W'(key);
               count_in     = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (!empty) begin
               status_in    = ST_OK;
               result_id_in = ITEM_ID_W'(entry_w[0]);
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               status_in    = ST_OK;
               result_id_in = ITEM_ID_W'(key);
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_QUERY: begin
            if (found) begin
               status_in    = ST_OK;
               result_id_in = ITEM_ID_W'(key);
               position_in  = POS_W'(pos_w);
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         result_id_ff <= result_id_in;
         position_ff  <= position_in;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.result_id = result_id_ff;
   assign rsp_bus.position  = position_ff;
   assign rsp_bus.count     = rsp_count_ff;

endmodule

FILE: hdl/fqkr_checker.sv
// fqkr_checker: port-level assertions for the keyed-removal identifier queue
// depends on fqkr_pkg; bound to fifo_queue_with_keyed_removal below
module fqkr_checker #(
   parameter int DEPTH = fqkr_pkg::DEPTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fqkr_pkg::STATUS_W-1:0]  status,
   input logic [fqkr_pkg::ITEM_ID_W-1:0] result_id,
   input logic [fqkr_pkg::POS_W-1:0]     position,
   input logic [fqkr_pkg::COUNT_W-1:0]   count
);
   import fqkr_pkg::*;

   // every accepted request shows a response in the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no response after accepted request");

   // a stalled response stays up
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // failed requests carry no id and no position
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != ST_OK)) |-> ((result_id == '0) && (position == '0)))
      else $error("failed request carries id or position");

   // a refused push reports a full queue
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status == ST_FULL)) |-> (count == COUNT_W'(DEPTH)))
      else $error("full status with count below depth");

endmodule

bind fifo_queue_with_keyed_removal fqkr_checker #(
   .DEPTH (DEPTH)
) u_fqkr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .status    (rsp_bus.status),
   .result_id (rsp_bus.result_id),
   .position  (rsp_bus.position),
   .count     (rsp_bus.count)
);

FILE: dv/testbench.sv
// testbench for fifo_queue_with_keyed_removal: directed and random requests, scoreboarded
// depends on fqkr_pkg, fqkr_req_if, fqkr_rsp_if and the queue rtl
`timescale 1ns / 1ps

module testbench;
   import fqkr_pkg::*;

   typedef struct packed {
      cmd_type                cmd;
      logic [ITEM_ID_W-1:0]   item_id;
   } request_type;

   typedef struct packed {
      status_type             status;
      logic [ITEM_ID_W-1:0]   result_id;
      logic [POS_W-1:0]       position;
      logic [COUNT_W-1:0]     count;
   } response_type;

   localparam int QUEUE_DEPTH   = DEPTH_DEF;
   localparam int HOLDOFF_START = 1300;
   localparam int HOLDOFF_LEN   = 120;

   logic clock;
   logic reset;

   fqkr_req_if req_bus ();
   fqkr_rsp_if rsp_bus ();

   fifo_queue_with_keyed_removal uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [ITEM_ID_W-1:0] held_ids[$];
   request_type          pending_requests[$];
   response_type         expected_rsps[$];
   request_type          next_req;
   response_type         exp_rsp;
   response_type         got_rsp;
   int                   total_requests = 0;
   int                   requests_accepted = 0;
   int                   failures = 0;
   int                   sender_idle_pct;
   int                   receiver_idle_pct;
   logic                 holdoff = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic response_type apply_queue_request(request_type req);
      response_type rsp;
      int           hit;
      rsp = '{status: ST_MISS, result_id: '0, position: '0, count: '0};
      hit = -1;
      if (req.cmd == CMD_REMOVE || req.cmd == CMD_QUERY) begin
         for (int i = 0; i < held_ids.size(); i++) begin
            if (hit < 0 && held_ids[i] == req.item_id) hit = i;
         end
      end
      case (req.cmd)
         CMD_PUSH: begin
            if (held_ids.size() >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               held_ids.push_back(req.item_id);
               rsp.status    = ST_OK;
               rsp.result_id = req.item_id;
            end
         end
         CMD_POP: begin
            if (held_ids.size() > 0) begin
               rsp.result_id = held_ids.pop_front();
               rsp.status    = ST_OK;
            end
         end
         CMD_REMOVE: begin
            if (hit >= 0) begin
               rsp.result_id = held_ids[hit];
               held_ids.delete(hit);
               rsp.status = ST_OK;
            end
         end
         default: begin
            if (hit >= 0) begin
               rsp.result_id = req.item_id;
               rsp.position  = POS_W'(hit);
               rsp.status    = ST_OK;
            end
         end
      endcase
      rsp.count = COUNT_W'(held_ids.size());
      return rsp;
   endfunction

   task automatic report_failure(string what, response_type exp, response_type act);
      failures++;
      if (failures <= 10) begin
         $display("%0t %s: expected status %0d id %h pos %0d count %0d, got status %0d id %h pos %0d count %0d",
                  $time, what, exp.status, exp.result_id, exp.position, exp.count,
                  act.status, act.result_id, act.position, act.count);
      end
   endtask

   task automatic add_request(cmd_type cmd, logic [ITEM_ID_W-1:0] item_id);
      pending_requests.push_back('{cmd: cmd, item_id: item_id});
      total_requests++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsps.push_back(apply_queue_request('{cmd: cmd_type'(req_bus.cmd),
                                                           item_id: req_bus.item_id}));
            requests_accepted++;
         end
         sender_idle_pct = (requests_accepted < 600) ? 27 :
                           (requests_accepted < 1200) ? 79 : 0;
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.cmd     <= next_req.cmd;
               req_bus.item_id <= next_req.item_id;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_rsp = '{status: status_type'(rsp_bus.status), result_id: rsp_bus.result_id,
                        position: rsp_bus.position, count: rsp_bus.count};
            if (expected_rsps.size() == 0) begin
               report_failure("unexpected response", '0, got_rsp);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got_rsp.status !== exp_rsp.status || got_rsp.result_id !== exp_rsp.result_id ||
                   got_rsp.position !== exp_rsp.position || got_rsp.count !== exp_rsp.count) begin
                  report_failure("response mismatch", exp_rsp, got_rsp);
               end
            end
         end
         receiver_idle_pct = (requests_accepted < 600) ? 79 :
                             (requests_accepted < 1200) ? 27 : 0;
         rsp_bus.ready <= !holdoff && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (requests_accepted >= HOLDOFF_START);
      @(posedge clock);
      holdoff <= 1'b1;
      repeat (HOLDOFF_LEN) @(posedge clock);
      holdoff <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [ITEM_ID_W-1:0] id_pool[4];
      logic [ITEM_ID_W-1:0] recent_ids[$];
      logic [ITEM_ID_W-1:0] key;
      int                   push_pct;
      int                   roll;
      cmd_type              op;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_PUSH;
      req_bus.item_id = '0;
      rsp_bus.ready   = 1'b0;

      // empty queue, extreme ids, duplicates, removal of the last entry
      add_request(CMD_POP,    16'h0000);
      add_request(CMD_REMOVE, 16'hFFFF);
      add_request(CMD_QUERY,  16'h0000);
      add_request(CMD_PUSH,   16'hFFFF);
      add_request(CMD_PUSH,   16'h0000);
      add_request(CMD_PUSH,   16'hFFFF);
      add_request(CMD_QUERY,  16'hFFFF);
      add_request(CMD_QUERY,  16'h0000);
      add_request(CMD_QUERY,  16'h1234);
      add_request(CMD_REMOVE, 16'hFFFF);
      add_request(CMD_QUERY,  16'hFFFF);
      add_request(CMD_REMOVE, 16'hFFFF);
      add_request(CMD_PUSH,   16'h5A5A);
      add_request(CMD_QUERY,  16'h5A5A);
      add_request(CMD_REMOVE, 16'h1234);
      add_request(CMD_POP,    16'hFFFF);
      add_request(CMD_POP,    16'h0000);
      add_request(CMD_POP,    16'h0000);

      // blocks that alternately fill, churn and drain the queue
      for (int blk = 0; blk < 34; blk++) begin
         push_pct = (blk % 3 == 0) ? 85 : (blk % 3 == 1) ? 50 : 15;
         foreach (id_pool[i]) id_pool[i] = ITEM_ID_W'($urandom);
         for (int n = 0; n < 50; n++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               add_request(cmd_type'($urandom_range(3)), ITEM_ID_W'($urandom));
            end else if (roll < push_pct) begin
               key = ($urandom_range(99) < 70) ? id_pool[$urandom_range(3)]
                                               : ITEM_ID_W'($urandom);
               recent_ids.push_back(key);
               if (recent_ids.size() > 24) void'(recent_ids.pop_front());
               add_request(CMD_PUSH, key);
            end else begin
               op   = cmd_type'($urandom_range(1, 3));
               roll = $urandom_range(99);
               if (roll < 60 && recent_ids.size() > 0) begin
                  key = recent_ids[$urandom_range(recent_ids.size() - 1)];
               end else if (roll < 85) begin
                  key = id_pool[$urandom_range(3)];
               end else begin
                  key = ITEM_ID_W'($urandom);
               end
               add_request(op, key);
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(negedge clock);
         if (requests_accepted == total_requests && expected_rsps.size() == 0) break;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      failures += expected_rsps.size();
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
